>>> rtl/kscl_pkg.sv
// Shared types and constants for the keypad scanner code lock.
`timescale 1ns / 1ps

package kscl_pkg;

    // Code length in keys and register reset values
    localparam logic [3:0]  CODE_LEN        = 4'd12;
    localparam logic [47:0] CODE_KEYS_RESET = 48'hFA63_3353_1A19;
    localparam logic [3:0]  CLEAR_KEY_RESET = 4'd12;

    // Configuration port geometry and register indexes
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 64;
    localparam logic REG_CODE_KEYS = 1'b0;
    localparam logic REG_CLEAR_KEY = 1'b1;

    // Scanner and sequencer state carried from tick to tick
    typedef struct packed {
        logic [1:0]  scan_row;
        logic [15:0] pressed_bits;
        logic        any_pressed;
        logic [3:0]  match_count;
        logic        open_flag;
    } scan_state_t;

    // One result beat
    typedef struct packed {
        logic [1:0]  row_drive;
        logic [15:0] key_map;
        logic        lock_open;
        logic [3:0]  progress;
    } result_t;

    // One-hot bit of a key index
    function automatic logic [15:0] key_bit(input logic [3:0] key);
        logic [15:0] onehot;
        onehot = 16'd1 << key;
        return onehot;
    endfunction

endpackage

>>> rtl/kscl_step.sv
// Next-state logic for one scan tick: key map update and code-lock sequencer.
`timescale 1ns / 1ps

module kscl_step (
    input  kscl_pkg::scan_state_t cur,
    input  logic [3:0]            column_levels,
    input  logic [47:0]           code_keys,
    input  logic [3:0]            clear_key,
    output kscl_pkg::scan_state_t nxt,
    output kscl_pkg::result_t     res
);

    logic [15:0] map_new;
    logic        trigger;
    logic [3:0]  cnt_base;
    logic [3:0]  expected;
    logic [3:0]  cnt_inc;

    // Replace the nibble of the row scanned on the previous tick
    always_comb begin
        map_new = cur.pressed_bits;
        map_new[{cur.scan_row, 2'b00} +: 4] = ~column_levels;
    end

    // Step the sequencer only when the map turns from empty to non-empty
    assign trigger  = !cur.any_pressed && (map_new != 16'd0);
    assign cnt_base = (cur.match_count >= kscl_pkg::CODE_LEN) ? 4'd0 : cur.match_count;
    assign expected = code_keys[{cnt_base[3:0], 2'b00} +: 4];
    assign cnt_inc  = cnt_base + 4'd1;

    always_comb begin
        nxt              = cur;
        nxt.scan_row     = cur.scan_row + 2'd1;
        nxt.pressed_bits = map_new;
        nxt.any_pressed  = (map_new != 16'd0);
        if (trigger) begin
            if (cur.open_flag) begin
                // While open, only the clear key closes the lock
                if (map_new == kscl_pkg::key_bit(clear_key)) begin
                    nxt.open_flag   = 1'b0;
                    nxt.match_count = 4'd0;
                end
            end else if (map_new == kscl_pkg::key_bit(expected)) begin
                nxt.match_count = cnt_inc;
                nxt.open_flag   = (cnt_inc == kscl_pkg::CODE_LEN);
            end else begin
                nxt.match_count = 4'd0;
            end
        end
    end

    // Pack the result beat from the updated state
    always_comb begin
        res.row_drive = nxt.scan_row;
        res.key_map   = nxt.pressed_bits;
        res.lock_open = nxt.open_flag;
        res.progress  = nxt.match_count;
    end

endmodule

>>> rtl/keypad_scan_code_lock_core.sv
// Top level of the matrix keypad scanner with code lock.
// Each result beat is registered in the output stage. Throughput: one input beat per
// cycle while s_ready is high; a two-entry output stage (result register plus
// skid register) keeps s_ready high while one finished result waits on m_ready.
// Reset: synchronous, active-low aresetn clears the scan and lock state and the output
// stage and reloads both configuration registers with their default values.
`timescale 1ns / 1ps

module keypad_scan_code_lock_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB-style configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kscl_pkg::ADDR_W-1:0]   paddr,
    input  logic [kscl_pkg::DATA_W-1:0]   pwdata,
    output logic [kscl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // Scan tick input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [3:0]                    s_column_levels,
    // Result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_row_drive,
    output logic [15:0]                   m_key_map,
    output logic                          m_lock_open,
    output logic [3:0]                    m_progress
);

    logic [47:0]           code_keys_reg;
    logic [3:0]            clear_key_reg;
    kscl_pkg::scan_state_t state_reg;
    kscl_pkg::scan_state_t state_next;
    kscl_pkg::result_t     result_next;
    kscl_pkg::result_t     out_reg;
    kscl_pkg::result_t     skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    logic                  cfg_write;
    logic                  in_beat;
    logic                  out_beat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign s_ready   = !skid_valid_reg;
    assign in_beat   = s_valid && s_ready;
    assign out_beat  = out_valid_reg && m_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_keys_reg <= kscl_pkg::CODE_KEYS_RESET;
            clear_key_reg <= kscl_pkg::CLEAR_KEY_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3])
                kscl_pkg::REG_CODE_KEYS: code_keys_reg <= pwdata[47:0];
                kscl_pkg::REG_CLEAR_KEY: clear_key_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[3])
            kscl_pkg::REG_CODE_KEYS: prdata = {16'd0, code_keys_reg};
            kscl_pkg::REG_CLEAR_KEY: prdata = {60'd0, clear_key_reg};
            default:                 prdata = '0;
        endcase
    end

    kscl_step u_step (
        .cur           (state_reg),
        .column_levels (s_column_levels),
        .code_keys     (code_keys_reg),
        .clear_key     (clear_key_reg),
        .nxt           (state_next),
        .res           (result_next)
    );

    // Advance scan state on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_beat) begin
            state_reg <= state_next;
        end
    end

    // Output stage: drain skid first, else load new result into the free slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_beat) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (in_beat) begin
            if (!out_valid_reg || out_beat) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_beat) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_beat) begin
                out_reg <= skid_reg;
            end
        end else if (in_beat) begin
            if (!out_valid_reg || out_beat) begin
                out_reg <= result_next;
            end else begin
                skid_reg <= result_next;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_row_drive = out_reg.row_drive;
    assign m_key_map   = out_reg.key_map;
    assign m_lock_open = out_reg.lock_open;
    assign m_progress  = out_reg.progress;

endmodule

>>> rtl/kscl_checker.sv
// Port-level checker for the keypad scanner code lock, bound to the top level.
`timescale 1ns / 1ps

module kscl_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [kscl_pkg::ADDR_W-1:0] paddr,
    input logic [kscl_pkg::DATA_W-1:0] pwdata,
    input logic [kscl_pkg::DATA_W-1:0] prdata,
    input logic                        pready,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [3:0]                  s_column_levels,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [1:0]                  m_row_drive,
    input logic [15:0]                 m_key_map,
    input logic                        m_lock_open,
    input logic [3:0]                  m_progress
);

    // A stalled result beat stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // Input side stalls only while a result is waiting
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output stage");

    // An open lock reports the full code length
    a_open: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_lock_open |-> m_progress == kscl_pkg::CODE_LEN)
        else $error("open lock with partial progress");

    // A closed lock never reports the full code length or more
    a_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_lock_open |-> m_progress < kscl_pkg::CODE_LEN)
        else $error("closed lock with full progress");

endmodule

bind keypad_scan_code_lock_core kscl_checker u_kscl_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench for the keypad scanner code lock core.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [kscl_pkg::ADDR_W-1:0] CODE_KEYS_ADDR = {kscl_pkg::REG_CODE_KEYS, 3'b000};
    localparam logic [kscl_pkg::ADDR_W-1:0] CLEAR_KEY_ADDR = {kscl_pkg::REG_CLEAR_KEY, 3'b000};
    localparam int RANDOM_TICKS = 80;
    localparam int STEADY_TICKS = 50;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [kscl_pkg::ADDR_W-1:0] paddr = '0;
    logic [kscl_pkg::DATA_W-1:0] pwdata = '0;
    logic [kscl_pkg::DATA_W-1:0] prdata;
    logic                        pready;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [3:0]                  s_column_levels = 4'hF;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [1:0]                  m_row_drive;
    logic [15:0]                 m_key_map;
    logic                        m_lock_open;
    logic [3:0]                  m_progress;

    // Scanner and lock state as the testbench expects it
    logic [1:0]  row_q = '0;
    logic [15:0] map_q = '0;
    logic        held_q = 1'b0;
    logic [3:0]  matched_q = '0;
    logic        open_q = 1'b0;
    logic [47:0] code_q = kscl_pkg::CODE_KEYS_RESET;
    logic [3:0]  clear_q = kscl_pkg::CLEAR_KEY_RESET;

    kscl_pkg::result_t expected_beats[$];
    int      mismatches = 0;
    int      ticks_sent = 0;
    bit      steady = 1'b0;

    keypad_scan_code_lock_core uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_column_levels (s_column_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_row_drive     (m_row_drive),
        .m_key_map       (m_key_map),
        .m_lock_open     (m_lock_open),
        .m_progress      (m_progress)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stall the result side at random, except during the steady stretch
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 36);
    end

    // Compare each result beat against the oldest expectation
    always @(posedge aclk) begin
        kscl_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: row %0d map %h open %0d progress %0d",
                             m_row_drive, m_key_map, m_lock_open, m_progress);
            end else begin
                want = expected_beats.pop_front();
                if (m_row_drive !== want.row_drive || m_key_map !== want.key_map ||
                    m_lock_open !== want.lock_open || m_progress !== want.progress) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: row %0d/%0d map %h/%h open %0d/%0d progress %0d/%0d",
                                 want.row_drive, m_row_drive, want.key_map, m_key_map,
                                 want.lock_open, m_lock_open, want.progress, m_progress);
                end
            end
        end
    end

    // Update the key map for one scan tick, step the lock, queue the result
    task automatic scan_and_step(input logic [3:0] levels);
        logic [3:0]        pressed;
        logic [3:0]        want_key;
        logic [15:0]       keep;
        kscl_pkg::result_t beat;
        pressed = ~levels;
        keep = map_q & ~(16'hF << {row_q, 2'b00});
        map_q = keep | ({12'd0, pressed} << {row_q, 2'b00});
        row_q = row_q + 2'd1;
        // step the sequencer only when the map turns non-empty
        if (!held_q && map_q != 16'd0) begin
            if (open_q) begin
                if (map_q == (16'd1 << clear_q)) begin
                    open_q = 1'b0;
                    matched_q = '0;
                end
            end else begin
                if (matched_q >= kscl_pkg::CODE_LEN)
                    matched_q = '0;
                want_key = code_q[matched_q * 4 +: 4];
                if (map_q == (16'd1 << want_key)) begin
                    matched_q = matched_q + 4'd1;
                    if (matched_q == kscl_pkg::CODE_LEN)
                        open_q = 1'b1;
                end else begin
                    matched_q = '0;
                end
            end
        end
        held_q = (map_q != 16'd0);
        beat.row_drive = row_q;
        beat.key_map = map_q;
        beat.lock_open = open_q;
        beat.progress = matched_q;
        expected_beats.push_back(beat);
    endtask

    // Send one scan tick beat, with random idle cycles ahead of it
    task automatic send_tick(input logic [3:0] levels);
        while (!steady && $urandom_range(0, 99) < 36) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_column_levels <= levels;
        do @(posedge aclk); while (!s_ready);
        scan_and_step(levels);
        ticks_sent++;
    endtask

    // Hold off the sender until every expected beat is back
    task automatic drain_results;
        if (s_valid)
            s_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle
    task automatic write_reg(input logic [kscl_pkg::ADDR_W-1:0] addr,
                             input logic [kscl_pkg::DATA_W-1:0] data);
        drain_results;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == CODE_KEYS_ADDR)
            code_q = data[47:0];
        else if (addr == CLEAR_KEY_ADDR)
            clear_q = data[3:0];
        @(posedge aclk);
    endtask

    task automatic release_all;
        repeat (4) send_tick(4'hF);
    endtask

    // Press one key on its row, hold it for extra scan rounds, then release
    task automatic press_key(input logic [3:0] key, input int hold_rounds);
        logic [3:0] low_col;
        low_col = ~(4'd1 << key[1:0]);
        if (map_q != 16'd0)
            release_all;
        while (row_q != key[3:2])
            send_tick(4'hF);
        send_tick(low_col);
        repeat (hold_rounds) begin
            repeat (3) send_tick(4'hF);
            send_tick(low_col);
        end
        release_all;
    endtask

    // Two or more columns low on one row
    task automatic press_chord;
        logic [3:0] levels;
        levels = 4'($urandom_range(0, 15));
        while ($countones(levels) > 2)
            levels = 4'($urandom_range(0, 15));
        if (map_q != 16'd0)
            release_all;
        send_tick(levels);
        release_all;
    endtask

    task automatic enter_keys(input int first, input int last);
        for (int i = first; i <= last; i++)
            press_key(code_q[i * 4 +: 4], int'($urandom_range(0, 9) == 0));
    endtask

    // Empty scans, all columns low, every row full, one column per row
    task automatic test_scan_corners;
        send_tick(4'hF);
        send_tick(4'h0);
        release_all;
        repeat (4) send_tick(4'h0);
        release_all;
        send_tick(4'hE);
        send_tick(4'hD);
        send_tick(4'hB);
        send_tick(4'h7);
        release_all;
    endtask

    // Open with the reset code; chords and other keys keep it open; clear closes
    task automatic test_default_code;
        enter_keys(0, kscl_pkg::CODE_LEN - 1);
        press_chord;
        press_key(clear_q + 4'd1, 0);
        press_key(code_q[3:0], 1);
        press_key(clear_q, 0);
    endtask

    // Clear key, chords and wrong keys send entry back to the start
    task automatic test_entry_aborts;
        enter_keys(0, 4);
        press_key(clear_q, 0);
        enter_keys(0, 2);
        press_chord;
        enter_keys(0, 1);
        press_key(code_q[11:8] ^ 4'h5, 2);
        press_key(code_q[3:0], 2);
        press_key(code_q[3:0], 0);
    endtask

    task automatic test_register_writes;
        // all-zero code with clear key zero: clear key counts as a code key
        write_reg(CODE_KEYS_ADDR, 64'd0);
        write_reg(CLEAR_KEY_ADDR, 64'd0);
        enter_keys(0, kscl_pkg::CODE_LEN - 1);
        press_key(4'd0, 0);
        // all-ones code with clear key fifteen
        write_reg(CODE_KEYS_ADDR, 64'h0000_FFFF_FFFF_FFFF);
        write_reg(CLEAR_KEY_ADDR, 64'd15);
        enter_keys(0, kscl_pkg::CODE_LEN - 1);
        press_key(4'd15, 0);
        // swap the code in the middle of entry; progress carries over
        write_reg(CODE_KEYS_ADDR, 64'h0000_0123_4567_89AB);
        enter_keys(0, 3);
        write_reg(CODE_KEYS_ADDR, 64'h0000_BA98_7654_3210);
        enter_keys(4, kscl_pkg::CODE_LEN - 1);
        // move the clear key while open
        write_reg(CLEAR_KEY_ADDR, 64'd5);
        press_key(4'd15, 0);
        press_key(4'd5, 0);
        write_reg(CODE_KEYS_ADDR, {16'd0, kscl_pkg::CODE_KEYS_RESET});
        write_reg(CLEAR_KEY_ADDR, {60'd0, kscl_pkg::CLEAR_KEY_RESET});
    endtask

    // Mostly code entries with random codes, mixed with mistakes, chords and noise
    task automatic test_random_traffic;
        int          stop_at;
        int          pick;
        logic [63:0] raw;
        stop_at = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < stop_at) begin
            // no idling on either side over the opening stretch
            steady = (ticks_sent < stop_at - (RANDOM_TICKS - STEADY_TICKS));
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                if ($urandom_range(0, 99) < 30)
                    enter_keys(0, $urandom_range(0, kscl_pkg::CODE_LEN - 2));
                else
                    enter_keys(0, kscl_pkg::CODE_LEN - 1);
            end else if (pick < 52) begin
                press_key(clear_q, $urandom_range(0, 1));
            end else if (pick < 62) begin
                press_chord;
            end else if (pick < 74) begin
                repeat ($urandom_range(1, 8)) send_tick(4'($urandom_range(0, 15)));
            end else if (pick < 79) begin
                drain_results;
            end else if (pick < 90) begin
                press_key(4'($urandom_range(0, 15)), $urandom_range(0, 1));
            end else begin
                raw = {$urandom, $urandom};
                if (raw[0])
                    write_reg(CODE_KEYS_ADDR, {16'd0, raw[47:0]});
                else
                    write_reg(CLEAR_KEY_ADDR, {60'd0, raw[63:60]});
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_scan_corners;
        test_default_code;
        test_entry_aborts;
        test_register_writes;
        test_random_traffic;
        drain_results;
        repeat (5) @(posedge aclk);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/kscl_pkg.sv
rtl/kscl_step.sv
rtl/keypad_scan_code_lock_core.sv
rtl/kscl_checker.sv
tb/tb_top.sv
